@@ rtl/est_pkg.sv @@
// Package for the environmental sensor trim compensation core.
// Holds payload and coefficient structs, register indexes and limits.
// No dependencies.
package est_pkg;

  localparam int DIV_STAGES = 64;

  localparam logic signed [31:0] TEMP_MIN  = -32'sd4000;
  localparam logic signed [31:0] TEMP_MAX  = 32'sd8500;
  localparam logic signed [63:0] PRESS_MAX = 64'sd33554431;
  localparam logic signed [31:0] HUM_MAX   = 32'sd419430400;

  typedef enum logic [2:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_LO = 3'd1,
    CFG_PRESS_HI = 3'd2,
    CFG_MIXED    = 3'd3,
    CFG_HUM      = 3'd4,
    CFG_HUM_EN   = 3'd5
  } est_cfg_idx_t;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
    logic [15:0] adc_humidity;
  } est_in_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [24:0]        press_q8;
    logic               press_valid;
    logic [16:0]        hum_q10;
  } est_out_t;

  // Fields that ride along the divider
  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [16:0]        hum_q10;
    logic               press_ok;
  } est_side_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } est_coef_t;

endpackage

@@ rtl/env_sensor_trim_compensation_core.sv @@
// Environmental sensor trim compensation core, top level.
// Stages: 11 front stages, 66 divider stages (64 quotient bits plus input and
// output registers), 6 back stages and the output register.
// Throughput: one sample per cycle while in_stall is low; a two-entry
// output register/skid keeps the pipeline running while one result waits.
// Synchronous reset clears the trim registers and all valid bits.
// Depends on est_pkg.
module env_sensor_trim_compensation_core import est_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  est_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output est_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0] temp_trim;
  logic [63:0] press_trim_low, press_trim_high;
  logic [47:0] mixed_trim;
  logic [31:0] hum_trim;
  logic        humidity_present;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim        <= '0;
      press_trim_low   <= '0;
      press_trim_high  <= '0;
      mixed_trim       <= '0;
      hum_trim         <= '0;
      humidity_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP:     temp_trim        <= cfg_data[47:0];
        CFG_PRESS_LO: press_trim_low   <= cfg_data;
        CFG_PRESS_HI: press_trim_high  <= cfg_data;
        CFG_MIXED:    mixed_trim       <= cfg_data[47:0];
        CFG_HUM:      hum_trim         <= cfg_data[31:0];
        CFG_HUM_EN:   humidity_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  est_coef_t coef;
  assign coef.t1 = temp_trim[15:0];
  assign coef.t2 = temp_trim[31:16];
  assign coef.t3 = temp_trim[47:32];
  assign coef.p1 = press_trim_low[15:0];
  assign coef.p2 = press_trim_low[31:16];
  assign coef.p3 = press_trim_low[47:32];
  assign coef.p4 = press_trim_low[63:48];
  assign coef.p5 = press_trim_high[15:0];
  assign coef.p6 = press_trim_high[31:16];
  assign coef.p7 = press_trim_high[47:32];
  assign coef.p8 = press_trim_high[63:48];
  assign coef.p9 = mixed_trim[15:0];
  assign coef.h1 = mixed_trim[23:16];
  assign coef.h2 = mixed_trim[39:24];
  assign coef.h3 = mixed_trim[47:40];
  assign coef.h4 = hum_trim[11:0];
  assign coef.h5 = hum_trim[23:12];
  assign coef.h6 = hum_trim[31:24];

  logic skid_valid;
  logic adv;
  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  logic               f_valid;
  logic signed [63:0] f_dvd;
  logic signed [30:0] f_dsr;
  est_side_t          f_side;

  est_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .coef      (coef),
    .hum_en    (humidity_present),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_dvd   (f_dvd),
    .out_dsr   (f_dsr),
    .out_side  (f_side)
  );

  logic               d_valid;
  logic signed [63:0] d_quo;
  est_side_t          d_side;

  est_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .dvd       (f_dvd),
    .dsr       (f_dsr),
    .in_side   (f_side),
    .out_valid (d_valid),
    .quo       (d_quo),
    .out_side  (d_side)
  );

  logic     p_valid;
  est_out_t p_data;

  est_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .coef      (coef),
    .in_valid  (d_valid),
    .quo       (d_quo),
    .in_side   (d_side),
    .out_valid (p_valid),
    .out_data  (p_data)
  );

  // output register plus one skid entry
  est_out_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (adv && p_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (adv && p_valid) begin
        skid_data <= p_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else begin
      out_data <= p_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a pending output");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled while output was free");

  a_press_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.press_valid) |-> (out_data.press_q8 == 25'd0))
    else $error("pressure nonzero with zero divisor");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.temp_centi >= -15'sd4000 && out_data.temp_centi <= 15'sd8500))
    else $error("temperature outside saturation limits");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hum_q10 <= 17'd102400))
    else $error("humidity above clamp");

endmodule

@@ rtl/est_front.sv @@
// Front pipeline: temperature, pressure dividend/divisor and humidity.
// Eleven register stages, one multiplier deep each. Depends on est_pkg.
module est_front import est_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  est_coef_t          coef,
  input  logic               hum_en,
  input  logic               in_valid,
  input  est_in_t            in_data,
  output logic               out_valid,
  output logic signed [63:0] out_dvd,
  output logic signed [30:0] out_dsr,
  output est_side_t          out_side
);

  localparam int NF = 11;

  logic [NF-1:0] vld;

  // coefficient extensions
  logic signed [31:0] t2_32, t3_32, h1_32, h2_32, h3_32, h4_32, h5_32, h6_32;
  assign t2_32 = 32'(coef.t2);
  assign t3_32 = 32'(coef.t3);
  assign h1_32 = $signed(32'(coef.h1));
  assign h2_32 = 32'(coef.h2);
  assign h3_32 = $signed(32'(coef.h3));
  assign h4_32 = 32'(coef.h4);
  assign h5_32 = 32'(coef.h5);
  assign h6_32 = 32'(coef.h6);

  // stage 1
  logic signed [17:0] ta;
  logic signed [16:0] tb;
  logic signed [31:0] ta32, tb32;
  assign ta   = $signed({1'b0, in_data.adc_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
  assign tb   = $signed({1'b0, in_data.adc_temperature[19:4]}) - $signed({1'b0, coef.t1});
  assign ta32 = 32'(ta);
  assign tb32 = 32'(tb);

  logic signed [31:0] s1_a, s1_bb;
  logic [19:0]        s1_adcp;
  logic [15:0]        s1_adch;

  // stage 2
  logic signed [31:0] s2_a, s2_b;
  logic [19:0]        s2_adcp;
  logic [15:0]        s2_adch;

  // stage 3
  logic signed [31:0] s3_tf;
  logic [19:0]        s3_adcp;
  logic [15:0]        s3_adch;

  // stage 4
  logic signed [31:0] tf5, trn;
  logic signed [14:0] temp_sat;
  assign tf5 = (s3_tf <<< 2) + s3_tf + 32'sd128;
  assign trn = tf5 >>> 8;
  always_comb begin
    if (trn < TEMP_MIN) begin
      temp_sat = 15'(TEMP_MIN);
    end else if (trn > TEMP_MAX) begin
      temp_sat = 15'(TEMP_MAX);
    end else begin
      temp_sat = trn[14:0];
    end
  end

  logic signed [32:0] s4_v1;
  logic signed [31:0] s4_x;
  logic signed [14:0] s4_temp;
  logic [19:0]        s4_adcp;
  logic [15:0]        s4_adch;

  // stage 5
  logic signed [65:0] v1sq;
  logic signed [48:0] m5, m2;
  assign v1sq = 66'(s4_v1) * 66'(s4_v1);
  assign m5   = 49'(s4_v1) * 49'(coef.p5);
  assign m2   = 49'(s4_v1) * 49'(coef.p2);

  logic signed [63:0] s5_sq;
  logic signed [48:0] s5_m5, s5_m2;
  logic signed [31:0] s5_hm5, s5_hx6, s5_hx3;
  logic signed [14:0] s5_temp;
  logic [19:0]        s5_adcp;
  logic [15:0]        s5_adch;

  // stage 6
  logic signed [31:0] ha;
  assign ha = $signed({2'b0, s5_adch, 14'b0}) - (h4_32 <<< 20) - s5_hm5 + 32'sd16384;

  logic signed [63:0] s6_v2a, s6_v1a;
  logic signed [48:0] s6_m5, s6_m2;
  logic signed [31:0] s6_ha, s6_hb1, s6_hc;
  logic signed [14:0] s6_temp;
  logic [19:0]        s6_adcp;

  // stage 7
  logic signed [63:0] s7_v2, s7_v1b;
  logic signed [31:0] s7_ha, s7_hb2;
  logic signed [14:0] s7_temp;
  logic [19:0]        s7_adcp;

  // stage 8
  logic signed [63:0] v1c, pd;
  logic [20:0]        pr;
  logic signed [31:0] hb3;
  assign v1c = (s7_v1b + 64'sh0000_8000_0000_0000) * $signed(64'(coef.p1));
  assign pr  = 21'h10_0000 - {1'b0, s7_adcp};
  assign pd  = ($signed({43'd0, pr}) <<< 31) - s7_v2;
  assign hb3 = ((s7_hb2 >>> 10) + 32'sd2097152) * h2_32 + 32'sd8192;

  logic signed [63:0] s8_pd;
  logic signed [30:0] s8_dsr;
  logic signed [31:0] s8_ha, s8_hb;
  logic signed [14:0] s8_temp;

  // stage 9
  logic signed [63:0] s9_dvd;
  logic signed [30:0] s9_dsr;
  logic signed [31:0] s9_hv;
  logic signed [14:0] s9_temp;

  // stage 10
  logic signed [31:0] hq;
  assign hq = s9_hv >>> 15;

  logic signed [63:0] s10_dvd;
  logic signed [30:0] s10_dsr;
  logic signed [31:0] s10_hv, s10_hsq;
  logic signed [14:0] s10_temp;

  // stage 11
  logic signed [31:0] hcorr, hv2;
  logic [16:0]        hum_val;
  assign hcorr = ((s10_hsq >>> 7) * h1_32) >>> 4;
  assign hv2   = s10_hv - hcorr;
  always_comb begin
    if (!hum_en || hv2 < 32'sd0) begin
      hum_val = '0;
    end else if (hv2 > HUM_MAX) begin
      hum_val = HUM_MAX[28:12];
    end else begin
      hum_val = hv2[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NF-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a    <= ta32 * t2_32;
      s1_bb   <= tb32 * tb32;
      s1_adcp <= in_data.adc_pressure;
      s1_adch <= in_data.adc_humidity;

      s2_a    <= s1_a >>> 11;
      s2_b    <= (s1_bb >>> 12) * t3_32;
      s2_adcp <= s1_adcp;
      s2_adch <= s1_adch;

      s3_tf   <= s2_a + (s2_b >>> 14);
      s3_adcp <= s2_adcp;
      s3_adch <= s2_adch;

      s4_v1   <= 33'(s3_tf) - 33'sd128000;
      s4_x    <= s3_tf - 32'sd76800;
      s4_temp <= temp_sat;
      s4_adcp <= s3_adcp;
      s4_adch <= s3_adch;

      s5_sq   <= v1sq[63:0];
      s5_m5   <= m5;
      s5_m2   <= m2;
      s5_hm5  <= h5_32 * s4_x;
      s5_hx6  <= s4_x * h6_32;
      s5_hx3  <= s4_x * h3_32;
      s5_temp <= s4_temp;
      s5_adcp <= s4_adcp;
      s5_adch <= s4_adch;

      s6_v2a  <= s5_sq * 64'(coef.p6);
      s6_v1a  <= s5_sq * 64'(coef.p3);
      s6_m5   <= s5_m5;
      s6_m2   <= s5_m2;
      s6_ha   <= ha >>> 15;
      s6_hb1  <= s5_hx6 >>> 10;
      s6_hc   <= (s5_hx3 >>> 11) + 32'sd32768;
      s6_temp <= s5_temp;
      s6_adcp <= s5_adcp;

      s7_v2   <= s6_v2a + (64'(s6_m5) <<< 17) + (64'(coef.p4) <<< 35);
      s7_v1b  <= (s6_v1a >>> 8) + (64'(s6_m2) <<< 12);
      s7_ha   <= s6_ha;
      s7_hb2  <= s6_hb1 * s6_hc;
      s7_temp <= s6_temp;
      s7_adcp <= s6_adcp;

      s8_pd   <= pd;
      s8_dsr  <= v1c[63:33];
      s8_ha   <= s7_ha;
      s8_hb   <= hb3 >>> 14;
      s8_temp <= s7_temp;

      s9_dvd  <= s8_pd * 64'sd3125;
      s9_dsr  <= s8_dsr;
      s9_hv   <= s8_ha * s8_hb;
      s9_temp <= s8_temp;

      s10_dvd  <= s9_dvd;
      s10_dsr  <= s9_dsr;
      s10_hv   <= s9_hv;
      s10_hsq  <= hq * hq;
      s10_temp <= s9_temp;

      out_dvd             <= s10_dvd;
      out_dsr             <= s10_dsr;
      out_side.temp_centi <= s10_temp;
      out_side.hum_q10    <= hum_val;
      out_side.press_ok   <= (s10_dsr != 31'sd0);
    end
  end

  assign out_valid = vld[NF-1];

endmodule

@@ rtl/est_div.sv @@
// Pipelined signed 64-by-31 bit divider, one quotient bit per stage.
// Quotient truncates toward zero and wraps to 64 bits. Depends on est_pkg.
module est_div import est_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [63:0] dvd,
  input  logic signed [30:0] dsr,
  input  est_side_t          in_side,
  output logic               out_valid,
  output logic signed [63:0] quo,
  output est_side_t          out_side
);

  logic [31:0]     rem   [0:DIV_STAGES];
  logic [63:0]     num   [0:DIV_STAGES];
  logic [30:0]     dmag  [0:DIV_STAGES];
  logic            neg   [0:DIV_STAGES];
  est_side_t       side  [0:DIV_STAGES];
  logic [DIV_STAGES:0] vld;

  // magnitudes; the most negative dividend maps to 2^63, which fits unsigned
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= '0;
      num[0]  <= dvd[63] ? 64'(-dvd) : 64'(dvd);
      dmag[0] <= dsr[30] ? 31'(-dsr) : 31'(dsr);
      neg[0]  <= dvd[63] ^ dsr[30];
      side[0] <= in_side;
    end
  end

  genvar k;
  for (k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [31:0] shifted;
    logic [32:0] trial;
    assign shifted = {rem[k-1][30:0], num[k-1][63]};
    assign trial   = {1'b0, shifted} - {2'b0, dmag[k-1]};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]  <= trial[32] ? shifted : trial[31:0];
        num[k]  <= {num[k-1][62:0], ~trial[32]};
        dmag[k] <= dmag[k-1];
        neg[k]  <= neg[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[DIV_STAGES-1:0], in_valid};
      out_valid <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quo      <= neg[DIV_STAGES] ? -$signed(num[DIV_STAGES]) : $signed(num[DIV_STAGES]);
      out_side <= side[DIV_STAGES];
    end
  end

endmodule

@@ rtl/est_back.sv @@
// Back pipeline: pressure correction terms after the division, clamping
// and result assembly. Six register stages. Depends on est_pkg.
module est_back import est_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  est_coef_t          coef,
  input  logic               in_valid,
  input  logic signed [63:0] quo,
  input  est_side_t          in_side,
  output logic               out_valid,
  output est_out_t           out_data
);

  localparam int NB = 6;

  logic [NB-1:0] vld;

  logic signed [63:0] b1_q, b1_qq, b1_w2m;
  est_side_t          b1_side;
  logic signed [63:0] b2_q, b2_qq, b2_w1a, b2_w2m;
  est_side_t          b2_side;
  logic [63:0]        b3_ll;
  logic [31:0]        b3_lh, b3_hl;
  logic signed [63:0] b3_q, b3_w2m;
  est_side_t          b3_side;
  logic signed [63:0] b4_q, b4_w1, b4_w2;
  est_side_t          b4_side;
  logic signed [63:0] b5_s;
  est_side_t          b5_side;

  // low 64 bits of the 64x64 product from 32-bit partial products
  logic signed [63:0] w1b;
  assign w1b = $signed(b3_ll + {b3_lh + b3_hl, 32'b0});

  logic signed [63:0] ps;
  logic [24:0]        press_sat;
  assign ps = (b5_s >>> 8) + (64'(coef.p7) <<< 4);
  always_comb begin
    if (!b5_side.press_ok || ps < 64'sd0) begin
      press_sat = '0;
    end else if (ps > PRESS_MAX) begin
      press_sat = PRESS_MAX[24:0];
    end else begin
      press_sat = ps[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NB-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_q    <= quo;
      b1_qq   <= quo >>> 13;
      b1_w2m  <= quo * 64'(coef.p8);
      b1_side <= in_side;

      b2_q    <= b1_q;
      b2_qq   <= b1_qq;
      b2_w1a  <= b1_qq * 64'(coef.p9);
      b2_w2m  <= b1_w2m;
      b2_side <= b1_side;

      b3_ll   <= 64'(b2_w1a[31:0]) * 64'(b2_qq[31:0]);
      b3_lh   <= b2_w1a[31:0] * b2_qq[63:32];
      b3_hl   <= b2_w1a[63:32] * b2_qq[31:0];
      b3_q    <= b2_q;
      b3_w2m  <= b2_w2m;
      b3_side <= b2_side;

      b4_q    <= b3_q;
      b4_w1   <= w1b >>> 25;
      b4_w2   <= b3_w2m >>> 19;
      b4_side <= b3_side;

      b5_s    <= b4_q + b4_w1 + b4_w2;
      b5_side <= b4_side;

      out_data.temp_centi  <= b5_side.temp_centi;
      out_data.press_q8    <= press_sat;
      out_data.press_valid <= b5_side.press_ok;
      out_data.hum_q10     <= b5_side.hum_q10;
    end
  end

  assign out_valid = vld[NB-1];

endmodule
